// ===== rtl/fatlb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Translation buffer package
// Operation codes, fixed result widths and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fatlb_pkg;

	localparam int OP_W = 2;

	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_INVAL  = 2'd2;

	// The returned page number is always 20 bits wide, whatever the page width.
	localparam int FOUND_BITS = 20;
	localparam int OUT_W      = ((1 + FOUND_BITS + 7) / 8) * 8;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;          // capture the incoming item
		logic exec;          // carry out the held operation and emit its result
		logic scan_init;     // begin the search for the oldest entry
		logic scan_step;     // compare one more entry's stamp
		logic write_victim;  // overwrite the chosen entry and emit the result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic ins_full;   // held item is an insert and every entry is valid
		logic scan_last;  // the scan is at the last entry
		logic out_free;   // the result register can take a result this cycle
	} sts_t;

endpackage

// ===== rtl/fatlb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Translation buffer controller
// Sequences one item at a time: capture, execute, and for an insert into a
// full buffer a scan for the oldest entry followed by the write.
// ----------------------------------------------------------------------------
module fatlb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fatlb_pkg::sts_t   sts,
	output fatlb_pkg::cmd_t   cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_WRITE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.ins_full) begin
					cmd.scan_init = 1'b1;
					state_d       = ST_SCAN;
				end else if (sts.out_free) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (sts.out_free) begin
					cmd.write_victim = 1'b1;
					state_d          = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/fatlb_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Translation buffer datapath
// Entry store with parallel tag and frame compare, the oldest-entry scan
// and the result register.
// ----------------------------------------------------------------------------
module fatlb_dp #(
	parameter int ENTRIES    = 16,
	parameter int PAGE_BITS  = 20,
	parameter int STAMP_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fatlb_pkg::cmd_t                cmd,
	output fatlb_pkg::sts_t                sts,
	input  logic [fatlb_pkg::OP_W-1:0]     in_op,
	input  logic [STAMP_BITS-1:0]          in_stamp,
	input  logic [PAGE_BITS-1:0]           in_vpage,
	input  logic [PAGE_BITS-1:0]           in_ppage,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           out_hit,
	output logic [fatlb_pkg::FOUND_BITS-1:0] out_page
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int FB    = fatlb_pkg::FOUND_BITS;

	// Held item.
	logic [fatlb_pkg::OP_W-1:0] op_q;
	logic [STAMP_BITS-1:0]      stamp_q;
	logic [PAGE_BITS-1:0]       vpage_q;
	logic [PAGE_BITS-1:0]       ppage_q;

	// Entry store.
	logic [ENTRIES-1:0]    ent_valid_q;
	logic [PAGE_BITS-1:0]  ent_tag_q   [ENTRIES];
	logic [PAGE_BITS-1:0]  ent_frame_q [ENTRIES];
	logic [STAMP_BITS-1:0] ent_stamp_q [ENTRIES];

	// Oldest-entry scan.
	logic [IDX_W-1:0]      scan_idx_q;
	logic [IDX_W-1:0]      victim_q;
	logic [STAMP_BITS-1:0] min_q;
	logic [STAMP_BITS-1:0] scan_stamp;

	// Result register.
	logic          out_valid_q;
	logic          out_hit_q;
	logic [FB-1:0] out_page_q;

	logic [ENTRIES-1:0]   tag_match;
	logic [ENTRIES-1:0]   frame_match;
	logic                 hit_any;
	logic [IDX_W-1:0]     hit_idx;
	logic [IDX_W-1:0]     free_idx;
	logic [PAGE_BITS-1:0] hit_frame;
	logic [PAGE_BITS+FB-1:0] hit_frame_ext;
	logic                 is_lookup;
	logic                 lookup_hit;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_idx;
	logic                 emit;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			tag_match[i]   = ent_valid_q[i] && (ent_tag_q[i] == vpage_q);
			frame_match[i] = ent_valid_q[i] && (ent_frame_q[i] == ppage_q);
		end
	end

	// Lowest matching entry and lowest free entry.
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (tag_match[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (!ent_valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign hit_any       = |tag_match;
	assign hit_frame     = ent_frame_q[hit_idx];
	assign hit_frame_ext = {{FB{1'b0}}, hit_frame};
	assign is_lookup     = (op_q == fatlb_pkg::OP_LOOKUP);
	assign lookup_hit    = is_lookup && hit_any;
	assign scan_stamp    = ent_stamp_q[scan_idx_q];

	assign wr_en  = (cmd.exec && (op_q == fatlb_pkg::OP_INSERT)) || cmd.write_victim;
	assign wr_idx = cmd.write_victim ? victim_q : free_idx;
	assign emit   = cmd.exec || cmd.write_victim;

	assign sts.ins_full  = (op_q == fatlb_pkg::OP_INSERT) && (&ent_valid_q);
	assign sts.scan_last = (scan_idx_q == IDX_W'(ENTRIES - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= in_op;
			stamp_q <= in_stamp;
			vpage_q <= in_vpage;
			ppage_q <= in_ppage;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= '0;
		end else if (wr_en) begin
			ent_valid_q[wr_idx] <= 1'b1;
		end else if (cmd.exec && (op_q == fatlb_pkg::OP_INVAL)) begin
			ent_valid_q <= ent_valid_q & ~frame_match;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_tag_q[wr_idx]   <= vpage_q;
			ent_frame_q[wr_idx] <= ppage_q;
			ent_stamp_q[wr_idx] <= stamp_q;
		end else if (cmd.exec && lookup_hit) begin
			ent_stamp_q[hit_idx] <= stamp_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			scan_idx_q <= IDX_W'(1);
			victim_q   <= '0;
			min_q      <= ent_stamp_q[0];
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + IDX_W'(1);
			if (scan_stamp < min_q) begin
				victim_q <= scan_idx_q;
				min_q    <= scan_stamp;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_hit_q  <= cmd.exec && lookup_hit;
			out_page_q <= (cmd.exec && lookup_hit) ? hit_frame_ext[FB-1:0] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_hit   = out_hit_q;
	assign out_page  = out_page_q;

endmodule

// ===== rtl/fully_associative_tlb_lru.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fully associative translation buffer with least-recently-used replacement
// A small address translation cache with lookup, insert and invalidate.
// ----------------------------------------------------------------------------
// Each item carries an operation in s_tuser: lookup (0), insert (1) or
// invalidate by physical page (2); code 3 does nothing. Every item gives
// exactly one result item. A lookup compares all tags at once, takes the
// lowest matching valid entry, returns its physical page with hit set and
// refreshes that entry's stamp with access_time; a miss returns hit clear and
// a zero page. An insert fills the lowest invalid entry; when every entry is
// valid it replaces the entry with the smallest stamp (plain unsigned compare,
// lowest index on a tie). An invalidate clears every valid entry whose
// physical page matches. Inserts do not check for an existing mapping, so a
// tag may be present twice; lookups then see the lower entry. An item is
// captured and then executed when the result register is free; an insert
// into a full buffer first walks the stamps one entry per cycle through a
// single comparator and then writes the chosen entry when the result
// register is free. The input is taken again as soon as the previous item
// has been executed, even if its result is still waiting in the output
// register. Valid bits clear at reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fully_associative_tlb_lru #(
	parameter int ENTRIES    = 16,
	parameter int PAGE_BITS  = 20,
	parameter int STAMP_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	// Input items.
	input  logic s_tvalid,
	output logic s_tready,
	// Fields from bit 0: access_time, virtual_page, physical_page, zero padding.
	input  logic [((STAMP_BITS + 2 * PAGE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// Fields from bit 0: op.
	input  logic [fatlb_pkg::OP_W-1:0] s_tuser,
	// Result items.
	output logic m_tvalid,
	input  logic m_tready,
	// Fields from bit 0: hit, found_page, zero padding.
	output logic [fatlb_pkg::OUT_W-1:0] m_tdata
);

	localparam int FB = fatlb_pkg::FOUND_BITS;

	fatlb_pkg::cmd_t cmd;
	fatlb_pkg::sts_t sts;

	logic [STAMP_BITS-1:0] in_stamp;
	logic [PAGE_BITS-1:0]  in_vpage;
	logic [PAGE_BITS-1:0]  in_ppage;
	logic                  out_hit;
	logic [FB-1:0]         out_page;

	// Unpack the input item; the padding bits above the last field are ignored.
	assign in_stamp = s_tdata[STAMP_BITS-1:0];
	assign in_vpage = s_tdata[STAMP_BITS +: PAGE_BITS];
	assign in_ppage = s_tdata[STAMP_BITS + PAGE_BITS +: PAGE_BITS];

	fatlb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fatlb_dp #(
		.ENTRIES    (ENTRIES),
		.PAGE_BITS  (PAGE_BITS),
		.STAMP_BITS (STAMP_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_op     (s_tuser),
		.in_stamp  (in_stamp),
		.in_vpage  (in_vpage),
		.in_ppage  (in_ppage),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_hit   (out_hit),
		.out_page  (out_page)
	);

	// Pack the result item, hit in the lowest bit.
	assign m_tdata = {{(fatlb_pkg::OUT_W - 1 - FB){1'b0}}, out_page, out_hit};

	// Only one item is in progress: having taken one, the input closes.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item was still in progress");

	// A result only appears in answer to an execute or a victim write.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.exec || cmd.write_victim))
		else $error("result appeared without a command that produces one");

	// The controller issues at most one command at a time.
	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.exec, cmd.scan_init, cmd.scan_step, cmd.write_victim}))
		else $error("more than one datapath command in a cycle");

	// The replacement scan only starts when the buffer is full.
	a_scan_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_init |-> sts.ins_full)
		else $error("replacement scan started with a free entry available");

endmodule
